[rtl/ida_pkg.sv]
`timescale 1ns / 1ps

package ida_pkg;

  // Width of the number that is converted and number of decimal digit slots.
  localparam int VALUE_BITS  = 64;
  localparam int DIGIT_SLOTS = 20;
  localparam int MAX_OUT     = 20;

  // A negative number spends one character on the sign.
  localparam int SLOTS_NEG = (DIGIT_SLOTS > MAX_OUT - 1) ? MAX_OUT - 1 : DIGIT_SLOTS;

  localparam int IN_VALUE_W = 64;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int BITS_W     = $clog2(VALUE_BITS + 1);
  localparam int POS_W      = $clog2(DIGIT_SLOTS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  typedef logic [VALUE_BITS-1:0] mag_t;
  typedef logic [DIGIT_W-1:0]    digit_t;
  typedef logic [BITS_W-1:0]     bits_t;
  typedef logic [POS_W-1:0]      pos_t;

  // Commands from the sequencer to the converter.
  typedef struct packed {
    logic start;
    logic shift_digit;
    mag_t magnitude;
  } conv_ctrl_t;

  // Status from the converter to the sequencer.
  typedef struct packed {
    logic   done;
    digit_t top_digit;
  } conv_stat_t;

endpackage

[rtl/ida_conv.sv]
`timescale 1ns / 1ps

// Bit-serial binary to BCD converter (shift and add 3). One magnitude bit
// enters the digit register per cycle; afterwards the digits can be shifted
// out one decimal digit per cycle, most significant slot first.
module ida_conv (
  input  logic                clk,
  input  logic                rst_n,
  input  ida_pkg::conv_ctrl_t ctrl,
  output ida_pkg::conv_stat_t stat
);

  ida_pkg::mag_t                                mag_r, mag_nxt;
  logic [ida_pkg::DIGIT_SLOTS-1:0][ida_pkg::DIGIT_W-1:0] bcd_r, bcd_nxt;
  logic [ida_pkg::DIGIT_SLOTS-1:0][ida_pkg::DIGIT_W-1:0] adj;
  logic [ida_pkg::DIGIT_SLOTS*ida_pkg::DIGIT_W-1:0]      adj_flat;
  ida_pkg::bits_t                               bits_r, bits_nxt;

  // Every digit of five or more is corrected by three before the doubling.
  always_comb begin
    for (int i = 0; i < ida_pkg::DIGIT_SLOTS; i++) begin
      adj[i] = (bcd_r[i] >= ida_pkg::DIGIT_W'(5)) ? bcd_r[i] + ida_pkg::DIGIT_W'(3)
                                                   : bcd_r[i];
    end
  end

  assign adj_flat = adj;

  // Load, shift one magnitude bit in, or shift one digit out.
  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    bits_nxt = bits_r;
    if (ctrl.start) begin
      mag_nxt  = ctrl.magnitude;
      bcd_nxt  = '0;
      bits_nxt = ida_pkg::BITS_W'(ida_pkg::VALUE_BITS);
    end else if (bits_r != '0) begin
      bcd_nxt  = {adj_flat[ida_pkg::DIGIT_SLOTS*ida_pkg::DIGIT_W-2:0],
                  mag_r[ida_pkg::VALUE_BITS-1]};
      mag_nxt  = {mag_r[ida_pkg::VALUE_BITS-2:0], 1'b0};
      bits_nxt = bits_r - ida_pkg::BITS_W'(1);
    end else if (ctrl.shift_digit) begin
      bcd_nxt = {bcd_r[ida_pkg::DIGIT_SLOTS-2:0], ida_pkg::DIGIT_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      mag_r  <= '0;
    end else begin
      bits_r <= bits_nxt;
      mag_r  <= mag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
  end

  assign stat.done      = (bits_r == '0);
  assign stat.top_digit = bcd_r[ida_pkg::DIGIT_SLOTS-1];

  // A start restarts the bit count at the full width.
  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |=> bits_r == ida_pkg::BITS_W'(ida_pkg::VALUE_BITS))
    else $error("conversion did not restart at full width");

  // The bit count only falls by one per cycle while converting.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (bits_r != '0 && !ctrl.start) |=> bits_r == $past(bits_r) - ida_pkg::BITS_W'(1))
    else $error("conversion bit count skipped");

  // A digit shift is only requested after the conversion has finished.
  a_shift_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.shift_digit |-> (bits_r == '0 && !ctrl.start))
    else $error("digit shifted during conversion");

endmodule

[rtl/ida_emit.sv]
`timescale 1ns / 1ps

// Sequencer: takes a number, runs the converter, drops leading zero digits,
// and sends the sign and the digits through the output register.
module ida_emit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic [ida_pkg::IN_VALUE_W-1:0]       in_value,
  input  logic                                 in_mode,
  output logic                                 in_stall,
  output logic                                 out_valid,
  output logic [ida_pkg::CHAR_W-1:0]           out_character,
  output logic                                 out_last,
  input  logic                                 out_stall,
  output ida_pkg::conv_ctrl_t                  ctrl,
  input  ida_pkg::conv_stat_t                  stat
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_SKIP  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      neg_r, neg_nxt;
  ida_pkg::pos_t             pos_r, pos_nxt;
  ida_pkg::pos_t             lim;
  logic                      out_valid_r, out_valid_nxt;
  logic [ida_pkg::CHAR_W-1:0] out_character_r, out_character_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      accept;
  logic                      out_free;
  ida_pkg::mag_t             raw;
  logic                      neg_in;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Incoming number and whether it is negative when read as two's complement (in_mode set).
  assign raw    = in_value[ida_pkg::VALUE_BITS-1:0];
  assign neg_in = in_mode && raw[ida_pkg::VALUE_BITS-1];

  assign lim = neg_r ? ida_pkg::POS_W'(ida_pkg::SLOTS_NEG)
                     : ida_pkg::POS_W'(ida_pkg::DIGIT_SLOTS);

  always_comb begin
    state_nxt         = state_r;
    neg_nxt           = neg_r;
    pos_nxt           = pos_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;
    ctrl.start        = 1'b0;
    ctrl.shift_digit  = 1'b0;
    ctrl.magnitude    = neg_in ? ida_pkg::VALUE_BITS'(~raw + ida_pkg::VALUE_BITS'(1)) : raw;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_nxt    = neg_in;
          ctrl.start = 1'b1;
          state_nxt  = ST_CONV;
        end
      end
      ST_CONV: begin
        if (stat.done) begin
          pos_nxt   = ida_pkg::POS_W'(ida_pkg::DIGIT_SLOTS);
          state_nxt = ST_SKIP;
        end
      end
      // Drop slots beyond the limit, then leading zeros, keeping one digit.
      ST_SKIP: begin
        if (pos_r > lim || (stat.top_digit == '0 && pos_r > ida_pkg::POS_W'(1))) begin
          ctrl.shift_digit = 1'b1;
          pos_nxt          = pos_r - ida_pkg::POS_W'(1);
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = ida_pkg::CHAR_MINUS;
          out_last_nxt      = 1'b0;
          neg_nxt           = 1'b0;
          state_nxt         = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = ida_pkg::CHAR_ZERO
                              + {{(ida_pkg::CHAR_W-ida_pkg::DIGIT_W){1'b0}}, stat.top_digit};
          out_last_nxt      = (pos_r == ida_pkg::POS_W'(1));
          ctrl.shift_digit  = 1'b1;
          pos_nxt           = pos_r - ida_pkg::POS_W'(1);
          if (pos_r == ida_pkg::POS_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      neg_r       <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      neg_r       <= neg_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  // Only the minus sign or a decimal digit ever leaves the block.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_character_r == ida_pkg::CHAR_MINUS ||
                     (out_character_r >= ida_pkg::CHAR_ZERO &&
                      out_character_r <= ida_pkg::CHAR_ZERO + ida_pkg::CHAR_W'(9))))
    else $error("character out of range");

  // The digit phase always has at least one digit left.
  a_digit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIGIT |-> pos_r != '0)
    else $error("digit phase with no digit left");

  // The sign is sent only for a negative number.
  a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SIGN |-> neg_r)
    else $error("sign phase for a non-negative number");

  // A beat marked last returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT && out_free && pos_r == ida_pkg::POS_W'(1)) |=>
      (state_r == ST_IDLE && out_last_r))
    else $error("last beat did not end the number");

endmodule

[rtl/integer_to_decimal_ascii_unit.sv]
`timescale 1ns / 1ps

// Sequence: the converter takes all magnitude bits, the sequencer sees the end, drops each
// unused slot, picks sign or digit, and the first character is registered. A new number is
// taken only after the last character of the previous one (in_stall is high meanwhile); the
// converter takes one bit per cycle, the output one digit per cycle while out_stall is low.
// Reset: synchronous active-low rst_n clears the sequencer, the magnitude and output valid;
// the digit register is not cleared and is fully rewritten by every conversion.
module integer_to_decimal_ascii_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [ida_pkg::IN_VALUE_W-1:0] in_value,
  input  logic                           in_mode,
  output logic                           in_stall,
  output logic                           out_valid,
  output logic [ida_pkg::CHAR_W-1:0]     out_character,
  output logic                           out_last,
  input  logic                           out_stall
);

  ida_pkg::conv_ctrl_t ctrl;
  ida_pkg::conv_stat_t stat;

  ida_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_value      (in_value),
    .in_mode       (in_mode),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last),
    .out_stall     (out_stall),
    .ctrl          (ctrl),
    .stat          (stat)
  );

  ida_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat)
  );

endmodule
